@@ design/uart_pkg.sv @@
// ----------------------------------------------------------------------------
// UART register block package
// Command codes, register addresses and the front-to-back queue entry type.
// ----------------------------------------------------------------------------
package uart_pkg;

	typedef enum logic [2:0] {
		CMD_WRITE = 3'd0,
		CMD_REGRD = 3'd1,
		CMD_LINE  = 3'd2,
		CMD_READY = 3'd3,
		CMD_TICK  = 3'd4
	} cmd_t;

	localparam logic [3:0] REG_DATA = 4'd0;
	localparam logic [3:0] REG_IER  = 4'd1;
	localparam logic [3:0] REG_FCR  = 4'd2;
	localparam logic [3:0] REG_LCR  = 4'd3;
	localparam logic [3:0] REG_MCR  = 4'd4;
	localparam logic [3:0] REG_LSR  = 4'd5;
	localparam logic [3:0] REG_MSR  = 4'd6;
	localparam logic [3:0] REG_SCR  = 4'd7;
	localparam logic [3:0] REG_RCH  = 4'd8;
	localparam logic [3:0] REG_WCH  = 4'd9;
	localparam logic [3:0] REG_EN   = 4'd10;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_WRITE = 3'd1,
		OP_READ  = 3'd2,
		OP_LINE  = 3'd3,
		OP_READY = 3'd4,
		OP_TICK  = 3'd5,
		OP_BAD   = 3'd6
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] addr;
		logic [7:0] data;
	} op_entry_t;

endpackage

@@ design/uart_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uart_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/uart_front.sv @@
// ----------------------------------------------------------------------------
// UART front end
// Accepts items, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module uart_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           cmd,
	input  logic [3:0]           reg_addr,
	input  logic [3:0]           access_size,
	input  logic [7:0]           write_data,
	input  logic [7:0]           line_byte,
	output logic                 q_valid,
	input  logic                 q_pop,
	output uart_pkg::op_entry_t  q_head
);
	import uart_pkg::*;

	op_entry_t ent_q [2];
	logic      rd_q, wr_q;
	logic [1:0] cnt_q;
	op_entry_t cls;
	logic      push;

	always_comb begin
		cls.addr = reg_addr;
		cls.data = write_data;
		case (cmd)
			CMD_WRITE, CMD_REGRD: begin
				if (access_size != 4'd1 || reg_addr > REG_EN) cls.op = OP_BAD;
				else cls.op = (cmd == CMD_WRITE) ? OP_WRITE : OP_READ;
			end
			CMD_LINE: begin
				cls.op = OP_LINE;
				cls.data = line_byte;
			end
			CMD_READY: cls.op = OP_READY;
			CMD_TICK:  cls.op = OP_TICK;
			default:   cls.op = OP_NONE;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2) || q_pop;
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_head   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

@@ design/uart_fifo.sv @@
// ----------------------------------------------------------------------------
// UART byte FIFO
// Circular buffer on a RAM with a registered look-ahead head byte.
// ----------------------------------------------------------------------------
module uart_fifo #(
	parameter int DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [7:0]             push_data,
	input  logic                   pop,
	output logic [7:0]             head,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [AW-1:0] rp_q, wp_q, rp_nx, raddr;
	logic [CW-1:0] cnt_q;
	logic [7:0]    ram_rd, byp_q;
	logic          byp_sel_q;

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		if (p == AW'(DEPTH - 1)) return '0;
		return p + 1'b1;
	endfunction

	assign rp_nx = pop ? inc(rp_q) : rp_q;
	assign raddr = rp_nx;

	uart_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(push), .waddr(wp_q), .wdata(push_data),
		.raddr(raddr), .rdata(ram_rd)
	);

	// head bypass when the new head is written in the same cycle
	always_ff @(posedge clk) begin
		byp_q     <= push_data;
		byp_sel_q <= push && (wp_q == rp_nx);
	end
	assign head  = byp_sel_q ? byp_q : ram_rd;
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else begin
			rp_q <= rp_nx;
			if (push) wp_q <= inc(wp_q);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end
endmodule

@@ design/uart_back.sv @@
// ----------------------------------------------------------------------------
// UART back end
// Carries out one classified operation per cycle on the register state, while the result output is not stalled.
// ----------------------------------------------------------------------------
module uart_back #(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  uart_pkg::op_entry_t q_head,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          read_data,
	output logic                bad_access,
	output logic                line_tx_valid,
	output logic [7:0]          line_tx_byte,
	output logic                line_rx_taken,
	output logic                read_irq,
	output logic [7:0]          read_irq_channel,
	output logic                write_irq,
	output logic [7:0]          write_irq_channel
);
	import uart_pkg::*;

	localparam int RCW = $clog2(RX_DEPTH+1);
	localparam int TCW = $clog2(TX_DEPTH+1);
	// compare width wide enough for both the TX count and the threshold
	localparam int TCX = (TCW > 4) ? TCW : 4;

	logic [RCW-1:0] rx_cnt;
	logic [TCW-1:0] tx_cnt;
	logic [7:0] rx_head, tx_head;
	logic rx_push, rx_pop, tx_push, tx_pop;
	logic [7:0] rx_pdata;

	logic [7:0] hold_q, inl_q, outl_q, scr_q, rch_q, wch_q;
	logic hold_full_q, inl_full_q, outl_full_q;
	logic rflag_q, wflag_q, ron_q, won_q, loop_q, on_q;
	logic [3:0] thr_q;

	// next-state values
	logic [7:0] hold_d, inl_d, outl_d, scr_d, rch_d, wch_d;
	logic hold_full_d, inl_full_d, outl_full_d;
	logic rflag_d, wflag_d, ron_d, won_d, loop_d, on_d;
	logic [3:0] thr_d;
	logic [7:0] rd_d, txb_d;
	logic bad_d, txv_d, taken_d;
	logic [TCX:0] tc;
	logic [RCW:0] rc;
	logic go;

	uart_fifo #(.DEPTH(RX_DEPTH)) u_rx (
		.clk(clk), .arst_n(arst_n), .push(rx_push), .push_data(rx_pdata),
		.pop(rx_pop), .head(rx_head), .count(rx_cnt)
	);
	uart_fifo #(.DEPTH(TX_DEPTH)) u_tx (
		.clk(clk), .arst_n(arst_n), .push(tx_push), .push_data(hold_q),
		.pop(tx_pop), .head(tx_head), .count(tx_cnt)
	);

	assign go    = q_valid && (!out_valid || out_ready);
	assign q_pop = go;

	always_comb begin
		hold_d = hold_q; inl_d = inl_q; outl_d = outl_q; scr_d = scr_q;
		rch_d = rch_q; wch_d = wch_q; hold_full_d = hold_full_q;
		inl_full_d = inl_full_q; outl_full_d = outl_full_q;
		rflag_d = rflag_q; wflag_d = wflag_q; ron_d = ron_q; won_d = won_q;
		loop_d = loop_q; on_d = on_q; thr_d = thr_q;
		rd_d = '0; txb_d = '0; bad_d = 1'b0; txv_d = 1'b0; taken_d = 1'b0;
		rx_push = 1'b0; rx_pop = 1'b0; tx_push = 1'b0; tx_pop = 1'b0;
		rx_pdata = inl_q;
		tc = (TCX+1)'(tx_cnt);
		rc = {1'b0, rx_cnt};
		if (go) begin
			case (q_head.op)
				OP_BAD: bad_d = 1'b1;
				OP_WRITE: begin
					case (q_head.addr)
						REG_DATA: begin
							hold_d = q_head.data;
							hold_full_d = 1'b1;
						end
						REG_IER: begin
							ron_d = q_head.data[0];
							won_d = q_head.data[1];
							if (q_head.data[0] && rx_cnt != '0) rflag_d = 1'b1;
							if (q_head.data[1] && tc < (TCX+1)'(thr_q) + 1'b1)
								wflag_d = 1'b1;
						end
						REG_FCR: begin
							case (q_head.data[7:6])
								2'd0: thr_d = 4'd1;
								2'd1: thr_d = 4'd4;
								2'd2: thr_d = 4'd8;
								default: thr_d = 4'd14;
							endcase
						end
						REG_MCR: loop_d = q_head.data[4];
						REG_SCR: scr_d = q_head.data;
						REG_RCH: rch_d = q_head.data;
						REG_WCH: wch_d = q_head.data;
						REG_EN: begin
							if (q_head.data == 8'd0 && on_q) begin
								wflag_d = 1'b0;
								rflag_d = 1'b0;
								on_d = 1'b0;
							end else if (q_head.data != 8'd0) begin
								on_d = 1'b1;
							end
						end
						default: ;
					endcase
				end
				OP_READ: begin
					case (q_head.addr)
						REG_DATA: begin
							if (rx_cnt != '0) begin
								if (rx_cnt == RCW'(1)) rflag_d = 1'b0;
								rd_d = rx_head;
								rx_pop = 1'b1;
							end
						end
						REG_IER: rd_d = {6'd0, won_q, ron_q};
						REG_FCR: begin
							rd_d = {2'b11, 5'd0, !(rflag_q || wflag_q)};
							if (rflag_q) rd_d[2] = 1'b1;
							else if (wflag_q) begin
								rd_d[1] = 1'b1;
								wflag_d = 1'b0;
							end
						end
						REG_LCR: rd_d = 8'd3;
						REG_MCR: rd_d = {3'd0, loop_q, 4'd0};
						REG_LSR: rd_d = {1'b0, tx_cnt == '0, !hold_full_q, 4'd0,
							rx_cnt != '0};
						REG_SCR: rd_d = scr_q;
						REG_RCH: rd_d = rch_q;
						REG_WCH: rd_d = wch_q;
						REG_EN:  rd_d = {7'd0, on_q};
						default: ;
					endcase
				end
				OP_LINE: begin
					if (on_q && !inl_full_q) begin
						inl_d = q_head.data;
						inl_full_d = 1'b1;
						taken_d = 1'b1;
					end
				end
				OP_READY: begin
					if (on_q && outl_full_q) begin
						txv_d = 1'b1;
						txb_d = outl_q;
						outl_full_d = 1'b0;
					end
				end
				OP_TICK: begin
					if (inl_full_q && !loop_q && rx_cnt < RCW'(RX_DEPTH)) begin
						rx_push = 1'b1;
						rc = rc + 1'b1;
						if (ron_q) rflag_d = 1'b1;
						inl_full_d = 1'b0;
					end
					if (hold_full_q && tx_cnt < TCW'(TX_DEPTH)) begin
						tx_push = 1'b1;
						tc = tc + 1'b1;
						if (tc >= (TCX+1)'(thr_q)) wflag_d = 1'b0;
						hold_full_d = 1'b0;
					end
					// head move uses the count before the hold push only when
					// the FIFO was empty: then the head is the pushed byte
					if (tc != '0) begin
						if (loop_q) begin
							if (rc < (RCW+1)'(RX_DEPTH)) begin
								rx_push = 1'b1;
								rx_pdata = (tx_cnt == '0) ? hold_q : tx_head;
								if (ron_q) rflag_d = 1'b1;
								tx_pop = 1'b1;
							end
						end else if (!outl_full_q) begin
							outl_d = (tx_cnt == '0) ? hold_q : tx_head;
							outl_full_d = 1'b1;
							tx_pop = 1'b1;
						end
						if (tx_pop && won_q && tc < (TCX+1)'(thr_q) + 1'b1)
							wflag_d = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0; inl_q <= '0; outl_q <= '0; scr_q <= '0;
			rch_q <= '0; wch_q <= '0; hold_full_q <= 1'b0;
			inl_full_q <= 1'b0; outl_full_q <= 1'b0; rflag_q <= 1'b0;
			wflag_q <= 1'b0; ron_q <= 1'b0; won_q <= 1'b0; loop_q <= 1'b0;
			on_q <= 1'b0; thr_q <= 4'd1; out_valid <= 1'b0;
		end else begin
			hold_q <= hold_d; inl_q <= inl_d; outl_q <= outl_d; scr_q <= scr_d;
			rch_q <= rch_d; wch_q <= wch_d; hold_full_q <= hold_full_d;
			inl_full_q <= inl_full_d; outl_full_q <= outl_full_d;
			rflag_q <= rflag_d; wflag_q <= wflag_d; ron_q <= ron_d;
			won_q <= won_d; loop_q <= loop_d; on_q <= on_d; thr_q <= thr_d;
			if (go) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			read_data         <= rd_d;
			bad_access        <= bad_d;
			line_tx_valid     <= txv_d;
			line_tx_byte      <= txb_d;
			line_rx_taken     <= taken_d;
			read_irq          <= rflag_d;
			read_irq_channel  <= rch_d;
			write_irq         <= wflag_d;
			write_irq_channel <= wch_d;
		end
	end
endmodule

@@ design/uart_register_block_with_fifos.sv @@
// Path: an accepted item is stored in the front-end queue, then the back end
// writes its result register, which holds while out_ready is low.
// Throughput: one item per cycle unless out_ready stalls the result register.
// Reset: arst_n clears all control state, FIFO counts, flags and enables;
// FIFO storage is not cleared and is only read after being written.
// ----------------------------------------------------------------------------
// UART register block with FIFOs
// 16550-style register file with RX and TX byte FIFOs, split into a
// classifying front end and an executing back end with a queue between.
// ----------------------------------------------------------------------------
module uart_register_block_with_fifos #(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cmd,
	input  logic [3:0] reg_addr,
	input  logic [3:0] access_size,
	input  logic [7:0] write_data,
	input  logic [7:0] line_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       bad_access,
	output logic       line_tx_valid,
	output logic [7:0] line_tx_byte,
	output logic       line_rx_taken,
	output logic       read_irq,
	output logic [7:0] read_irq_channel,
	output logic       write_irq,
	output logic [7:0] write_irq_channel
);
	import uart_pkg::*;

	// transfer queue between front and back
	logic      q_valid, q_pop;
	op_entry_t q_head;

	uart_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .reg_addr(reg_addr), .access_size(access_size),
		.write_data(write_data), .line_byte(line_byte),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	// back end owns all register state and both FIFOs
	uart_back #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head), .out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .bad_access(bad_access),
		.line_tx_valid(line_tx_valid), .line_tx_byte(line_tx_byte),
		.line_rx_taken(line_rx_taken), .read_irq(read_irq),
		.read_irq_channel(read_irq_channel), .write_irq(write_irq),
		.write_irq_channel(write_irq_channel)
	);
endmodule

@@ verif/uart_register_block_with_fifos_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART register block testbench
// Drives register accesses, line events and ticks; a scoreboard class
// predicts every result from its own register/FIFO model and checks it.
// ----------------------------------------------------------------------------
module uart_register_block_with_fifos_test;
	import uart_pkg::*;

	localparam int RXD = 16;
	localparam int TXD = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] rdata;
		logic       bad;
		logic       txv;
		logic [7:0] txb;
		logic       taken;
		logic       rirq;
		logic [7:0] rch;
		logic       wirq;
		logic [7:0] wch;
	} uart_result_t;

	// Register and FIFO model; predicts one result per transfer.
	class uart_scoreboard;
		byte unsigned rxq[$];
		byte unsigned txq[$];
		byte unsigned hold_b, in_b, out_b, scr, rch, wch;
		bit hold_f, in_f, out_f, rflag, wflag, ren, wen, loopb, on;
		int thresh;
		uart_result_t pending[$];
		int errors;

		function new();
			thresh = 1;
		endfunction

		function void rx_add(byte unsigned b, output bit ok);
			ok = rxq.size() < RXD;
			if (ok) begin
				rxq.push_back(b);
				if (ren) rflag = 1;
			end
		endfunction

		function void do_tick();
			bit ok;
			bit moved;
			if (in_f && !loopb) begin
				rx_add(in_b, ok);
				if (ok) in_f = 0;
			end
			if (hold_f && txq.size() < TXD) begin
				txq.push_back(hold_b);
				if (txq.size() >= thresh) wflag = 0;
				hold_f = 0;
			end
			if (txq.size() != 0) begin
				moved = 0;
				if (loopb) begin
					rx_add(txq[0], moved);
				end else if (!out_f) begin
					out_b = txq[0];
					out_f = 1;
					moved = 1;
				end
				if (moved) begin
					if (wen && txq.size() < thresh + 1) wflag = 1;
					void'(txq.pop_front());
				end
			end
		endfunction

		function void note_transfer(logic [2:0] c, logic [3:0] a, logic [3:0] sz,
				logic [7:0] d, logic [7:0] lb);
			uart_result_t r;
			r = '0;
			if (c == CMD_WRITE || c == CMD_REGRD) begin
				if (sz != 1 || a > REG_EN) r.bad = 1;
				else if (c == CMD_WRITE) begin
					case (a)
						REG_DATA: begin hold_b = d; hold_f = 1; end
						REG_IER: begin
							ren = d[0];
							wen = d[1];
							if (ren && rxq.size() != 0) rflag = 1;
							if (wen && txq.size() < thresh + 1) wflag = 1;
						end
						REG_FCR: thresh = (d[7:6] == 0) ? 1 : (d[7:6] == 1) ? 4 :
							(d[7:6] == 2) ? 8 : 14;
						REG_MCR: loopb = d[4];
						REG_SCR: scr = d;
						REG_RCH: rch = d;
						REG_WCH: wch = d;
						REG_EN: begin
							if (d == 0 && on) begin
								rflag = 0; wflag = 0; on = 0;
							end else if (d != 0) on = 1;
						end
						default: ;
					endcase
				end else begin
					case (a)
						REG_DATA: if (rxq.size() != 0) begin
							if (rxq.size() == 1) rflag = 0;
							r.rdata = rxq.pop_front();
						end
						REG_IER: r.rdata = {6'd0, wen, ren};
						REG_FCR: begin
							r.rdata = 8'hC0 | ((rflag || wflag) ? 8'd0 : 8'd1);
							if (rflag) r.rdata |= 8'h04;
							else if (wflag) begin r.rdata |= 8'h02; wflag = 0; end
						end
						REG_LCR: r.rdata = 8'd3;
						REG_MCR: r.rdata = loopb ? 8'h10 : 8'h00;
						REG_LSR: r.rdata = {1'b0, txq.size() == 0, !hold_f, 4'd0,
							rxq.size() != 0};
						REG_SCR: r.rdata = scr;
						REG_RCH: r.rdata = rch;
						REG_WCH: r.rdata = wch;
						REG_EN: r.rdata = {7'd0, on};
						default: ;
					endcase
				end
			end else if (c == CMD_LINE) begin
				if (on && !in_f) begin in_b = lb; in_f = 1; r.taken = 1; end
			end else if (c == CMD_READY) begin
				if (on && out_f) begin r.txv = 1; r.txb = out_b; out_f = 0; end
			end else if (c == CMD_TICK) do_tick();
			r.rirq = rflag; r.rch = rch; r.wirq = wflag; r.wch = wch;
			pending.push_back(r);
		endfunction

		function void check_result(uart_result_t got);
			uart_result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.rdata !== exp.rdata)
				$display("%0t: read_data expected %h actual %h", $time, exp.rdata, got.rdata);
			if (got.bad !== exp.bad)
				$display("%0t: bad_access expected %h actual %h", $time, exp.bad, got.bad);
			if (got.txv !== exp.txv)
				$display("%0t: line_tx_valid expected %h actual %h", $time, exp.txv, got.txv);
			if (got.txb !== exp.txb)
				$display("%0t: line_tx_byte expected %h actual %h", $time, exp.txb, got.txb);
			if (got.taken !== exp.taken)
				$display("%0t: line_rx_taken expected %h actual %h", $time, exp.taken,
					got.taken);
			if (got.rirq !== exp.rirq)
				$display("%0t: read_irq expected %h actual %h", $time, exp.rirq, got.rirq);
			if (got.rch !== exp.rch)
				$display("%0t: read_irq_channel expected %h actual %h", $time, exp.rch,
					got.rch);
			if (got.wirq !== exp.wirq)
				$display("%0t: write_irq expected %h actual %h", $time, exp.wirq, got.wirq);
			if (got.wch !== exp.wch)
				$display("%0t: write_irq_channel expected %h actual %h", $time, exp.wch,
					got.wch);
			if (got !== exp) errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] cmd = '0;
	logic [3:0] reg_addr = '0;
	logic [3:0] access_size = 4'd1;
	logic [7:0] write_data = '0;
	logic [7:0] line_byte = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [7:0] read_data, line_tx_byte, read_irq_channel, write_irq_channel;
	logic bad_access, line_tx_valid, line_rx_taken, read_irq, write_irq;

	uart_register_block_with_fifos uut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	uart_scoreboard sb = new();
	int cycles = 0;
	bit calm = 0;        // no idling on either side
	bit rx_hold = 0;     // receiver long hold-off request
	bit done_sending = 0;

	// Monitor: sample at the rising edge, feed scoreboard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready)
			sb.note_transfer(cmd, reg_addr, access_size, write_data, line_byte);
		if (arst_n && out_valid && out_ready)
			sb.check_result({read_data, bad_access, line_tx_valid, line_tx_byte,
				line_rx_taken, read_irq, read_irq_channel, write_irq, write_irq_channel});
	end

	// Receiver: random stalls, plus a long counted hold-off on request.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ready <= 0;
				for (n = 0; n < 60; n++) @(negedge clk);
				rx_hold = 0;
			end
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
		end
	end

	// One transfer; inputs change on the falling edge only.
	// Valid is left high after the transfer: the next call either replaces
	// the payload or drops valid, and drain drops it before waiting.
	task automatic send(logic [2:0] c, logic [3:0] a, logic [3:0] sz,
			logic [7:0] d, logic [7:0] lb);
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		cmd <= c; reg_addr <= a; access_size <= sz; write_data <= d; line_byte <= lb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wr(logic [3:0] a, logic [7:0] d);
		send(CMD_WRITE, a, 4'd1, d, 8'($urandom));
	endtask

	task automatic rd(logic [3:0] a);
		send(CMD_REGRD, a, 4'd1, 8'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		in_valid <= 0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// Random item, weighted toward useful traffic.
	task automatic random_item();
		int k;
		logic [3:0] a;
		k = $urandom_range(99);
		a = 4'($urandom_range(10));
		if (k < 5) send($urandom_range(1) ? CMD_WRITE : CMD_REGRD,
			4'($urandom_range(15)), 4'($urandom_range(15)), 8'($urandom),
			8'($urandom));
		else if (k < 12) send(3'($urandom_range(5, 7)), 4'($urandom), 4'($urandom),
			8'($urandom), 8'($urandom));
		else if (k < 22) wr(REG_DATA, 8'($urandom));
		else if (k < 28) wr(a, (a == REG_EN) ? ($urandom_range(3) == 0 ? 8'd0 :
			8'($urandom)) : 8'($urandom));
		else if (k < 38) rd(REG_DATA);
		else if (k < 46) rd(a);
		else if (k < 60) send(CMD_LINE, 4'($urandom), 4'($urandom), 8'($urandom),
			8'($urandom));
		else if (k < 72) send(CMD_READY, 4'($urandom), 4'($urandom), 8'($urandom),
			8'($urandom));
		else send(CMD_TICK, 4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int i;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: every register read at reset, then walk the special cases.
		for (i = 0; i <= 10; i++) rd(4'(i));
		send(CMD_LINE, 4'd0, 4'd1, 8'd0, 8'hFF);        // line byte while off
		rd(4'd11);                                      // bad address
		send(CMD_WRITE, REG_SCR, 4'd8, 8'hFF, 8'd0);    // bad size
		wr(REG_EN, 8'hFF);
		wr(REG_IER, 8'h03);
		wr(REG_FCR, 8'hC0);
		wr(REG_DATA, 8'h00);
		wr(REG_DATA, 8'hFF);                            // overwrite of the hold register
		send(CMD_LINE, 4'd0, 4'd1, 8'd0, 8'hA5);
		send(CMD_LINE, 4'd0, 4'd1, 8'd0, 8'h5A);        // latch busy
		send(CMD_TICK, 4'd0, 4'd1, 8'd0, 8'd0);
		send(CMD_READY, 4'd0, 4'd1, 8'd0, 8'd0);
		rd(REG_FCR);
		rd(REG_DATA);
		rd(REG_DATA);                                   // empty RX read
		wr(REG_EN, 8'h00);

		// Random phases with different threshold / loopback settings.
		for (i = 0; i < 1300; i++) begin
			if (i % 260 == 0) begin
				drain();
				repeat (4) @(negedge clk);
				wr(REG_EN, 8'h01);
				wr(REG_FCR, 8'($urandom_range(3) << 6));
				wr(REG_MCR, (i / 260) % 2 ? 8'h10 : 8'hEF);
				wr(REG_RCH, (i == 0) ? 8'hFF : 8'($urandom));
				wr(REG_WCH, (i == 0) ? 8'h00 : 8'($urandom));
				wr(REG_IER, 8'($urandom));
			end
			calm = (i >= 500 && i < 650);
			if (i == 300) rx_hold = 1;
			if (i == 800) begin
				drain();
			end
			random_item();
		end
		in_valid <= 0;
		calm = 0;
		done_sending = 1;
	end

	initial begin
		wait (done_sending);
		while (sb.pending.size() != 0 && cycles < CYCLE_LIMIT) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** uart_register_block_with_fifos: PASSED **");
		else
			$display("** uart_register_block_with_fifos: FAILED **");
		$finish;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("%0t: cycle limit reached", $time);
		$display("** uart_register_block_with_fifos: FAILED **");
		$finish;
	end
endmodule

@@ uart_register_block_with_fifos.f @@
design/uart_pkg.sv
design/uart_ram.sv
design/uart_front.sv
design/uart_fifo.sv
design/uart_back.sv
design/uart_register_block_with_fifos.sv
verif/uart_register_block_with_fifos_test.sv
